@@ hw/rtl/rfx_pkg.sv @@
// Shared types and constants for the receive FIFO with XON/XOFF flow control.
package rfx_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } rfx_in_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [1:0] flow_send;
    logic [7:0] level;
  } rfx_out_t;

  typedef enum logic [1:0] {
    FLOW_NONE = 2'd0,
    FLOW_XOFF = 2'd1,
    FLOW_XON  = 2'd2
  } rfx_flow_t;

  // Result fields known at accept time; the data byte follows from the ring read.
  typedef struct packed {
    logic       data_valid;
    rfx_flow_t  flow_send;
    logic [7:0] level;
  } rfx_stat_t;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic REG_HIGH_WATER = 1'b0;
  localparam logic REG_LOW_WATER  = 1'b1;

  localparam logic [7:0] HIGH_WATER_RST = 8'd192;
  localparam logic [7:0] LOW_WATER_RST  = 8'd64;
  localparam logic [7:0] LEVEL_MAX      = 8'hFF;

endpackage

@@ hw/rtl/rfx_ring_mem.sv @@
// Ring storage: one write port and one registered read port.
module rfx_ring_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata_r
);

  logic [7:0] ring_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ring_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= ring_mem[raddr];
    end
  end

endmodule

@@ hw/rtl/rfx_ctrl.sv @@
// Pointer, fill count, watermark registers and XON/XOFF decision logic.
module rfx_ctrl #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [7:0]          cfg_wdata,
  input  logic                accept,
  input  rfx_pkg::rfx_in_t    item,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [7:0]          mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  output rfx_pkg::rfx_stat_t  stat_r
);
  import rfx_pkg::*;

  localparam int CMPW = (AW > 8) ? AW : 8;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] count_r, count_nxt;
  logic          xoff_r, xoff_nxt;
  logic [7:0]    high_r, low_r;
  logic [AW-1:0] wr_next, rd_next, count_dec;
  logic [CMPW-1:0] count_ext;
  rfx_stat_t     stat_nxt;

  always_comb begin
    wr_next    = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
    rd_next    = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
    count_dec  = (count_r == '0) ? '0 : count_r - AW'(1);
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    xoff_nxt   = xoff_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = wr_next;
    mem_wdata  = item.rx_byte;
    mem_raddr  = rd_next;
    stat_nxt.data_valid = 1'b0;
    stat_nxt.flow_send  = FLOW_NONE;
    if (accept) begin
      if (item.kind == KIND_ENQ) begin
        if (item.rx_byte != 8'd0) begin
          // XOFF decision uses the count before the store, even if the byte is dropped
          if (CMPW'(count_r) > CMPW'(high_r)) begin
            stat_nxt.flow_send = FLOW_XOFF;
            xoff_nxt           = 1'b1;
          end
          if (wr_next != rd_ptr_r) begin
            mem_we     = 1'b1;
            wr_ptr_nxt = wr_next;
            count_nxt  = count_r + AW'(1);
          end
        end
      end else if (wr_ptr_r != rd_ptr_r) begin
        count_nxt = count_dec;
        if ((CMPW'(count_dec) < CMPW'(low_r)) && xoff_r) begin
          xoff_nxt           = 1'b0;
          stat_nxt.flow_send = FLOW_XON;
        end
        rd_ptr_nxt          = rd_next;
        mem_re              = 1'b1;
        stat_nxt.data_valid = 1'b1;
      end
    end
    count_ext      = CMPW'(count_nxt);
    stat_nxt.level = (count_ext > CMPW'(LEVEL_MAX)) ? LEVEL_MAX : count_ext[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      xoff_r   <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      xoff_r   <= xoff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r <= HIGH_WATER_RST;
      low_r  <= LOW_WATER_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_HIGH_WATER: high_r <= cfg_wdata;
        REG_LOW_WATER:  low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stat_r <= stat_nxt;
    end
  end

endmodule

@@ hw/rtl/rx_fifo_xon_xoff_core.sv @@
// Top level: receive ring buffer with XON/XOFF flow requests.
//
// Each item is an enqueue of a received byte or a dequeue request, and yields
// exactly one result. The ring lives in a single synchronous RAM of DEPTH bytes
// (DEPTH-1 usable); pointers, fill count and the XOFF flag sit in registers and
// are updated in the cycle an item is accepted, while the ring read for a dequeue
// is issued in that same cycle. One item per clock is accepted whenever the
// result path is not backed up. RAM read data and result fields are captured at
// the accepting edge; the output register then loads from them once it is empty
// or not stalled.
// No clearing pass after reset is needed: entries are read only after written.
module rx_fifo_xon_xoff_core #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  rfx_pkg::rfx_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rfx_pkg::rfx_out_t out_data
);
  import rfx_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic          accept;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata_r;
  rfx_stat_t     stat_r;
  logic          s1_valid_r, s1_valid_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_take;
  rfx_out_t      out_data_r;

  assign out_take = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_take;
  assign accept   = in_valid && !in_stall;

  rfx_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .item      (in_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .stat_r    (stat_r)
  );

  rfx_ring_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata_r)
  );

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (out_take) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid_r) begin
      out_data_r.data_valid <= stat_r.data_valid;
      out_data_r.data_byte  <= stat_r.data_valid ? mem_rdata_r : 8'd0;
      out_data_r.flow_send  <= stat_r.flow_send;
      out_data_r.level      <= stat_r.level;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
